>>> rtl/core/bcpc_pkg.sv
// Shared types, constants and helpers for the button press classifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bcpc_pkg;

  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned NowWidth     = 32;
  localparam int unsigned DurWidth     = 32;
  localparam int unsigned ThrWidth     = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrWidth = 2;
  localparam int unsigned FifoCntWidth = 3;

  typedef logic [TimeWidth-1:0] time_t;
  typedef logic [ThrWidth-1:0]  thr_t;

  typedef enum logic [2:0] {
    EvClick    = 3'd0,
    EvDouble   = 3'd1,
    EvLong     = 3'd2,
    EvVeryLong = 3'd3,
    EvStart    = 3'd4,
    EvEnd      = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    StIdle     = 4'b0001,
    StDebounce = 4'b0010,
    StPressed  = 4'b0100,
    StWait     = 4'b1000
  } state_e;

  localparam logic [1:0] MstIdle     = 2'd0;
  localparam logic [1:0] MstDebounce = 2'd1;
  localparam logic [1:0] MstPressed  = 2'd2;
  localparam logic [1:0] MstWait     = 2'd3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegEnabled     = 3'd0,
    RegActiveLevel = 3'd1,
    RegDebounce    = 3'd2,
    RegGap         = 3'd3,
    RegLong        = 3'd4,
    RegVeryLong    = 3'd5
  } reg_e;

  typedef struct packed {
    logic enabled;
    logic active_level;
    thr_t debounce_ms;
    thr_t double_click_gap_ms;
    thr_t long_press_ms;
    thr_t very_long_press_ms;
  } cfg_t;

  typedef struct packed {
    event_e                code;
    logic [DurWidth-1:0]   duration;
    logic [1:0]            mstate;
    logic                  last;
  } evt_t;

  typedef struct packed {
    logic [1:0] cnt;
    evt_t       e0;
    evt_t       e1;
  } push_t;

  function automatic logic [1:0] state_code(state_e st);
    logic [1:0] code;
    unique case (st)
      StIdle:     code = MstIdle;
      StDebounce: code = MstDebounce;
      StPressed:  code = MstPressed;
      StWait:     code = MstWait;
      default:    code = MstIdle;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bcpc_intf.sv
// Handshake interfaces of the classifier: poll input, event output, register writes.
// Depends on bcpc_pkg for field widths.
`default_nettype none

interface bcpc_poll_if import bcpc_pkg::*;;
  logic                valid;
  logic                ready;
  logic                button_level;
  logic [NowWidth-1:0] now_ms;
  modport source(output valid, button_level, now_ms, input ready);
  modport sink(input valid, button_level, now_ms, output ready);
endinterface

interface bcpc_evt_if import bcpc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [2:0]          event_code;
  logic [DurWidth-1:0] duration_ms;
  logic [1:0]          machine_state;
  logic                last_of_run;
  modport source(output valid, event_code, duration_ms, machine_state, last_of_run,
                 input ready);
  modport sink(input valid, event_code, duration_ms, machine_state, last_of_run,
               output ready);
endinterface

interface bcpc_cfg_if import bcpc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/button_click_press_classifier.sv
// Top level of the button press classifier: register file, state machine, result queue.
// Depends on bcpc_pkg, bcpc_intf, bcpc_cfg_regs, bcpc_fsm and bcpc_evt_fifo.
//
//   port     dir  word                                               handshake
//   poll_i   in   button_level, now_ms                               valid/ready
//   evt_o    out  event_code, duration_ms, machine_state, last_of_run valid/ready
//   cfg_i    in   index, data                                        valid/ready
//
// A poll is registered on acceptance and classified once the queue has room for two
// words; its events are then written into the queue. Polls flow one per cycle while
// the four-word queue has that room; two events of one poll leave one at a time.
// Output stalls back up through the queue into poll_i.ready. Reset loads the register
// defaults, empties the queue and idles the machine; cfg_i.ready is always high.
`default_nettype none

module button_click_press_classifier import bcpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcpc_poll_if.sink   poll_i,
  bcpc_evt_if.source  evt_o,
  bcpc_cfg_if.sink    cfg_i
);

  cfg_t  cfg;
  logic  clear;
  logic  room;
  push_t push;

  bcpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  bcpc_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .poll_i  (poll_i),
    .cfg_i   (cfg),
    .clear_i (clear),
    .room_i  (room),
    .push_o  (push)
  );

  bcpc_evt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .evt_o  (evt_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/bcpc_cfg_regs.sv
// Configuration register file of the classifier; flags a disable write.
// Depends on bcpc_pkg and bcpc_cfg_if.
`default_nettype none

module bcpc_cfg_regs import bcpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcpc_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o,
  output logic       clear_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;
  assign cfg_o       = cfg_q;
  assign clear_o     = wr && (reg_e'(cfg_i.index) == RegEnabled) && !cfg_i.data[0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (reg_e'(cfg_i.index))
        RegEnabled:     cfg_d.enabled             = cfg_i.data[0];
        RegActiveLevel: cfg_d.active_level        = cfg_i.data[0];
        RegDebounce:    cfg_d.debounce_ms         = thr_t'(cfg_i.data);
        RegGap:         cfg_d.double_click_gap_ms = thr_t'(cfg_i.data);
        RegLong:        cfg_d.long_press_ms       = thr_t'(cfg_i.data);
        RegVeryLong:    cfg_d.very_long_press_ms  = thr_t'(cfg_i.data);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled             <= 1'b1;
      cfg_q.active_level        <= 1'b0;
      cfg_q.debounce_ms         <= thr_t'(50);
      cfg_q.double_click_gap_ms <= thr_t'(500);
      cfg_q.long_press_ms       <= thr_t'(1000);
      cfg_q.very_long_press_ms  <= thr_t'(5000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bcpc_fsm.sv
// Poll input register and press state machine; turns one poll into up to two events.
// Depends on bcpc_pkg and bcpc_poll_if.
`default_nettype none

module bcpc_fsm import bcpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcpc_poll_if.sink  poll_i,
  input  cfg_t       cfg_i,
  input  logic       clear_i,
  input  logic       room_i,
  output push_t      push_o
);

  logic   s1_valid_q, s1_valid_d;
  logic   s1_level_q;
  time_t  s1_now_q;
  logic   accept, fire, step;

  state_e state_q, state_d;
  time_t  deb_q, deb_d, press_q, press_d, click_q, click_d;
  logic [1:0] cnt_q, cnt_d, cnt_inc;
  logic   lf_q, lf_d, vlf_q, vlf_d;

  logic   active;
  time_t  deb_diff, dur, gap_diff;
  time_t  deb_thr, gap_thr, long_thr, very_thr;
  logic [1:0] n;
  event_e c0, c1;
  time_t  d0, d1;

  assign fire          = s1_valid_q && room_i;
  assign step          = fire && cfg_i.enabled;
  assign poll_i.ready  = !s1_valid_q || fire;
  assign accept        = poll_i.valid && poll_i.ready;
  assign s1_valid_d    = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_level_q <= poll_i.button_level;
      s1_now_q   <= time_t'(poll_i.now_ms);
    end
  end

  assign active   = s1_level_q == cfg_i.active_level;
  assign deb_diff = s1_now_q - deb_q;
  assign dur      = s1_now_q - press_q;
  assign gap_diff = s1_now_q - click_q;
  assign deb_thr  = time_t'(cfg_i.debounce_ms);
  assign gap_thr  = time_t'(cfg_i.double_click_gap_ms);
  assign long_thr = time_t'(cfg_i.long_press_ms);
  assign very_thr = time_t'(cfg_i.very_long_press_ms);
  assign cnt_inc  = cnt_q + 2'd1;

  always_comb begin
    state_d = state_q;
    deb_d   = deb_q;
    press_d = press_q;
    click_d = click_q;
    cnt_d   = cnt_q;
    lf_d    = lf_q;
    vlf_d   = vlf_q;
    n       = 2'd0;
    c0      = EvClick;
    c1      = EvClick;
    d0      = '0;
    d1      = '0;
    unique case (state_q)
      StIdle: begin
        if (active) begin
          state_d = StDebounce;
          deb_d   = s1_now_q;
        end
      end
      StDebounce: begin
        if (deb_diff >= deb_thr) begin
          if (active) begin
            state_d = StPressed;
            press_d = s1_now_q;
            n       = 2'd1;
            c0      = EvStart;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StPressed: begin
        if (!active) begin
          n     = 2'd1;
          c0    = EvEnd;
          d0    = dur;
          lf_d  = 1'b0;
          vlf_d = 1'b0;
          if (dur < long_thr) begin
            state_d = StWait;
            click_d = s1_now_q;
            cnt_d   = 2'd1;
          end else begin
            state_d = StDebounce;
            deb_d   = s1_now_q;
            n       = 2'd2;
            c1      = (dur < very_thr) ? EvLong : EvVeryLong;
            d1      = dur;
          end
        end else begin
          if (!lf_q && dur >= long_thr) begin
            if (dur < very_thr) begin
              n  = 2'd1;
              c0 = EvLong;
              d0 = dur;
            end
            lf_d = 1'b1;
          end
          if (!vlf_q && dur >= very_thr) begin
            n     = 2'd1;
            c0    = EvVeryLong;
            d0    = dur;
            vlf_d = 1'b1;
          end
        end
      end
      StWait: begin
        if (gap_diff > gap_thr) begin
          if (cnt_q == 2'd1) begin
            n  = 2'd1;
            c0 = EvClick;
          end
          state_d = StIdle;
          cnt_d   = 2'd0;
        end else if (active) begin
          if (cnt_inc == 2'd2) begin
            state_d = StIdle;
            cnt_d   = 2'd0;
            n       = 2'd1;
            c0      = EvDouble;
          end else begin
            state_d = StDebounce;
            deb_d   = s1_now_q;
            cnt_d   = cnt_inc;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    push_o.cnt         = step ? n : 2'd0;
    push_o.e0.code     = c0;
    push_o.e0.duration = DurWidth'(d0);
    push_o.e0.mstate   = state_code(state_d);
    push_o.e0.last     = n == 2'd1;
    push_o.e1.code     = c1;
    push_o.e1.duration = DurWidth'(d1);
    push_o.e1.mstate   = state_code(state_d);
    push_o.e1.last     = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      deb_q   <= '0;
      press_q <= '0;
      click_q <= '0;
      cnt_q   <= 2'd0;
      lf_q    <= 1'b0;
      vlf_q   <= 1'b0;
    end else if (clear_i) begin
      state_q <= StIdle;
      deb_q   <= '0;
      press_q <= '0;
      click_q <= '0;
      cnt_q   <= 2'd0;
      lf_q    <= 1'b0;
      vlf_q   <= 1'b0;
    end else if (step) begin
      state_q <= state_d;
      deb_q   <= deb_d;
      press_q <= press_d;
      click_q <= click_d;
      cnt_q   <= cnt_d;
      lf_q    <= lf_d;
      vlf_q   <= vlf_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bcpc_evt_fifo.sv
// Four-word result queue; takes up to two event words a cycle, hands out one.
// Depends on bcpc_pkg and bcpc_evt_if.
`default_nettype none

module bcpc_evt_fifo import bcpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  push_t       push_i,
  output logic        room_o,
  bcpc_evt_if.source  evt_o
);

  evt_t mem_q [FifoDepth];
  logic [FifoPtrWidth-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [FifoCntWidth-1:0] cnt_q, cnt_d;
  logic pop;
  evt_t head;

  assign room_o = cnt_q <= FifoCntWidth'(FifoDepth - 2);
  assign head   = mem_q[rd_q];
  assign pop    = evt_o.valid && evt_o.ready;
  assign wr_nxt = wr_q + FifoPtrWidth'(1);

  assign evt_o.valid         = cnt_q != '0;
  assign evt_o.event_code    = head.code;
  assign evt_o.duration_ms   = head.duration;
  assign evt_o.machine_state = head.mstate;
  assign evt_o.last_of_run   = head.last;

  assign wr_d  = wr_q + FifoPtrWidth'(push_i.cnt);
  assign rd_d  = pop ? rd_q + FifoPtrWidth'(1) : rd_q;
  assign cnt_d = cnt_q + FifoCntWidth'(push_i.cnt) - FifoCntWidth'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.e1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bcpc_checker.sv
// Port-level checks on the event channel of the classifier, bound to the top level.
// Depends on bcpc_pkg and button_click_press_classifier.
`default_nettype none

module bcpc_checker import bcpc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                evt_valid_i,
  input logic                evt_ready_i,
  input logic [2:0]          evt_code_i,
  input logic [DurWidth-1:0] evt_dur_i,
  input logic [1:0]          evt_state_i,
  input logic                evt_last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i &&
      $stable({evt_code_i, evt_dur_i, evt_state_i, evt_last_i}))
    else $error("event word dropped or changed while stalled");

  a_no_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && (evt_code_i == EvClick || evt_code_i == EvDouble ||
      evt_code_i == EvStart) |-> evt_dur_i == '0)
    else $error("duration set on an event without one");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_code_i == EvStart |-> evt_state_i == MstPressed && evt_last_i)
    else $error("press start not alone or not in pressed state");

  a_click_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && (evt_code_i == EvClick || evt_code_i == EvDouble) |->
      evt_state_i == MstIdle)
    else $error("click event without return to idle");

endmodule

bind button_click_press_classifier bcpc_checker u_bcpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .evt_valid_i (evt_o.valid),
  .evt_ready_i (evt_o.ready),
  .evt_code_i  (evt_o.event_code),
  .evt_dur_i   (evt_o.duration_ms),
  .evt_state_i (evt_o.machine_state),
  .evt_last_i  (evt_o.last_of_run)
);

`default_nettype wire

>>> tb/tb_button_click_press_classifier.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_click_press_classifier: a clocked driver and
// monitor around the block, with a predictor of the press classifier in this file.
// Depends on bcpc_pkg, bcpc_intf and the RTL of the block.

module tb_button_click_press_classifier;
  import bcpc_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit    = 600000;

  localparam logic [CfgIdxWidth-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegSpare7 = 3'd7;

  typedef struct packed {
    logic                level;
    logic [NowWidth-1:0] now;
  } poll_t;

  // default thresholds, active level low
  localparam poll_t DirectedPolls [21] = '{
    '{1'b0, 32'd1000}, '{1'b0, 32'd1020}, '{1'b0, 32'd1050}, '{1'b1, 32'd1150},
    '{1'b1, 32'd1700}, '{1'b0, 32'd1800}, '{1'b0, 32'd1860}, '{1'b1, 32'd1900},
    '{1'b0, 32'd2000}, '{1'b0, 32'd2100}, '{1'b1, 32'd2200}, '{1'b0, 32'd2300},
    '{1'b0, 32'd2350}, '{1'b0, 32'd3400}, '{1'b0, 32'd7400}, '{1'b1, 32'd7500},
    '{1'b1, 32'd7600}, '{1'b0, 32'hFFFF_FFF0}, '{1'b0, 32'h0000_0030},
    '{1'b1, 32'h0000_0500}, '{1'b1, 32'hFFFF_FFFF}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bcpc_poll_if poll_if ();
  bcpc_evt_if  evt_if ();
  bcpc_cfg_if  cfg_if ();

  button_click_press_classifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .poll_i (poll_if),
    .evt_o  (evt_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  poll_t poll_backlog [$];
  evt_t  event_log [$];
  int    errors = 0;
  int    poll_gap = 0;
  int    stall_left = 0;
  int    cycle_count = 0;
  logic  src_idle_on = 1'b0;
  logic  sink_idle_on = 1'b0;
  logic  quiet_tail = 1'b0;
  logic  squeeze_go = 1'b0;
  logic  sink_hold = 1'b0;

  // classifier copy: configuration
  logic       cf_enabled = 1'b1;
  logic       cf_active_level = 1'b0;
  thr_t       cf_debounce = 16'd50;
  thr_t       cf_gap = 16'd500;
  thr_t       cf_long = 16'd1000;
  thr_t       cf_vlong = 16'd5000;

  // classifier copy: machine
  logic [1:0] cls_mode = MstIdle;
  time_t      cls_deb_start = '0;
  time_t      cls_press_start = '0;
  time_t      cls_click_time = '0;
  logic [1:0] cls_clicks = '0;
  logic       cls_long_done = 1'b0;
  logic       cls_vlong_done = 1'b0;

  event_e              step_code [2];
  logic [DurWidth-1:0] step_dur [2];
  int                  step_n;

  function automatic void note_event(event_e code, logic [DurWidth-1:0] dur);
    if (step_n < 2) begin
      step_code[step_n] = code;
      step_dur[step_n] = dur;
      step_n++;
    end
  endfunction

  function automatic void classify_poll(logic level, logic [NowWidth-1:0] now);
    logic  active;
    time_t dur;
    step_n = 0;
    if (!cf_enabled) return;
    active = (level == cf_active_level);
    case (cls_mode)
      MstIdle: begin
        if (active) begin
          cls_mode = MstDebounce;
          cls_deb_start = now;
        end
      end
      MstDebounce: begin
        dur = now - cls_deb_start;
        if (dur >= {16'd0, cf_debounce}) begin
          if (active) begin
            cls_mode = MstPressed;
            cls_press_start = now;
            note_event(EvStart, '0);
          end else begin
            cls_mode = MstIdle;
          end
        end
      end
      MstPressed: begin
        dur = now - cls_press_start;
        if (!active) begin
          note_event(EvEnd, dur);
          cls_long_done = 1'b0;
          cls_vlong_done = 1'b0;
          if (dur < {16'd0, cf_long}) begin
            cls_mode = MstWait;
            cls_click_time = now;
            cls_clicks = 2'd1;
          end else begin
            cls_mode = MstDebounce;
            cls_deb_start = now;
            if (dur < {16'd0, cf_vlong}) note_event(EvLong, dur);
            else note_event(EvVeryLong, dur);
          end
        end else begin
          if (!cls_long_done && dur >= {16'd0, cf_long}) begin
            if (dur < {16'd0, cf_vlong}) note_event(EvLong, dur);
            cls_long_done = 1'b1;
          end
          if (!cls_vlong_done && dur >= {16'd0, cf_vlong}) begin
            note_event(EvVeryLong, dur);
            cls_vlong_done = 1'b1;
          end
        end
      end
      default: begin
        dur = now - cls_click_time;
        if (dur > {16'd0, cf_gap}) begin
          if (cls_clicks == 2'd1) note_event(EvClick, '0);
          cls_mode = MstIdle;
          cls_clicks = 2'd0;
        end else if (active) begin
          cls_clicks = cls_clicks + 2'd1;
          if (cls_clicks == 2'd2) begin
            cls_mode = MstIdle;
            cls_clicks = 2'd0;
            note_event(EvDouble, '0);
          end else begin
            cls_mode = MstDebounce;
            cls_deb_start = now;
          end
        end
      end
    endcase
    for (int k = 0; k < step_n; k++) begin
      event_log.push_back('{code: step_code[k], duration: step_dur[k], mstate: cls_mode,
                            last: (k == step_n - 1)});
    end
  endfunction

  function automatic void apply_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
    case (idx)
      RegEnabled: begin
        cf_enabled = d[0];
        if (!d[0]) begin
          cls_mode = MstIdle;
          cls_deb_start = '0;
          cls_press_start = '0;
          cls_click_time = '0;
          cls_clicks = '0;
          cls_long_done = 1'b0;
          cls_vlong_done = 1'b0;
        end
      end
      RegActiveLevel: cf_active_level = d[0];
      RegDebounce:    cf_debounce = d;
      RegGap:         cf_gap = d;
      RegLong:        cf_long = d;
      RegVeryLong:    cf_vlong = d;
      default: ;
    endcase
  endfunction

  // well-formed press/release runs with random lengths, plus some noise
  function automatic void plan_presses(int count, logic [NowWidth-1:0] start, int step_hi,
                                       int hold_hi, int noise_pct);
    logic [NowWidth-1:0] t;
    logic                pressing;
    int                  seg_left;
    int                  step;
    poll_t               p;
    t = start;
    pressing = 1'b0;
    seg_left = $urandom_range(1, hold_hi);
    for (int i = 0; i < count; i++) begin
      step = $urandom_range(0, step_hi);
      t += step;
      seg_left -= step;
      if (seg_left <= 0) begin
        pressing = !pressing;
        if (pressing || $urandom_range(0, 1)) seg_left = $urandom_range(1, hold_hi);
        else seg_left = $urandom_range(1, hold_hi / 4 + 1);
      end
      p.level = pressing ? cf_active_level : !cf_active_level;
      p.now = t;
      if ($urandom_range(0, 99) < noise_pct) begin
        p.level = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
          t = $urandom;
          p.now = t;
        end
      end
      poll_backlog.push_back(p);
    end
  endfunction

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, d);
  endtask

  task automatic set_thresholds(thr_t deb, thr_t gap, thr_t lng, thr_t vlng);
    write_reg(RegDebounce, deb);
    write_reg(RegGap, gap);
    write_reg(RegLong, lng);
    write_reg(RegVeryLong, vlng);
  endtask

  task automatic drain_and_wait();
    while (poll_backlog.size() != 0 || poll_if.valid || event_log.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic disabled_interlude(int count);
    write_reg(RegEnabled, 16'hFFFE);
    plan_presses(count, $urandom, 100, 300, 50);
    drain_and_wait();
    write_reg(RegEnabled, 16'h0001);
  endtask

  always @(posedge clk_i) begin : poll_driver
    poll_t nxt;
    if (rst_ni) begin
      if (poll_if.valid && poll_if.ready) classify_poll(poll_if.button_level, poll_if.now_ms);
      if (!poll_if.valid || poll_if.ready) begin
        if (poll_gap > 0) begin
          poll_gap--;
          poll_if.valid <= 1'b0;
        end else if (poll_backlog.size() > 0) begin
          nxt = poll_backlog.pop_front();
          poll_if.valid <= 1'b1;
          poll_if.button_level <= nxt.level;
          poll_if.now_ms <= nxt.now;
          if (src_idle_on && !quiet_tail && $urandom_range(0, 5) == 0)
            poll_gap = $urandom_range(1, 11);
        end else begin
          poll_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : event_monitor
    evt_t got;
    evt_t want;
    if (rst_ni) begin
      if (evt_if.valid && evt_if.ready) begin
        got = '{code: event_e'(evt_if.event_code), duration: evt_if.duration_ms,
                mstate: evt_if.machine_state, last: evt_if.last_of_run};
        if (event_log.size() == 0) begin
          errors++;
          $display("%0t: unexpected event: expected none,", $time,
                   " got code=%0d dur=%0d state=%0d last=%0b",
                   got.code, got.duration, got.mstate, got.last);
        end else begin
          want = event_log.pop_front();
          if (got.code !== want.code || got.duration !== want.duration ||
              got.mstate !== want.mstate || got.last !== want.last) begin
            errors++;
            $display("%0t: event mismatch: expected code=%0d dur=%0d state=%0d last=%0b,",
                     $time, want.code, want.duration, want.mstate, want.last,
                     " got code=%0d dur=%0d state=%0d last=%0b",
                     got.code, got.duration, got.mstate, got.last);
          end
        end
      end
      if (sink_hold) begin
        evt_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        evt_if.ready <= 1'b0;
      end else begin
        evt_if.ready <= 1'b1;
        if (sink_idle_on && !quiet_tail && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 11);
      end
    end
  end

  initial begin : backpressure
    wait (squeeze_go);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_button_click_press_classifier: done, errors");
    $finish;
  end

  initial begin : stimulus
    int round;
    poll_if.valid = 1'b0;
    poll_if.button_level = 1'b0;
    poll_if.now_ms = '0;
    evt_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedPolls[i]) poll_backlog.push_back(DirectedPolls[i]);
    drain_and_wait();

    disabled_interlude(6);
    write_reg(RegSpare6, CfgDataWidth'($urandom));
    write_reg(RegSpare7, 16'hFFFF);

    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    write_reg(RegActiveLevel, 16'h0001);
    set_thresholds(16'd5, 16'd40, 16'd60, 16'd150);
    plan_presses(350, 32'h0000_1000, 8, 220, 5);
    drain_and_wait();

    disabled_interlude(5);

    // all thresholds at zero
    src_idle_on = 1'b0;
    write_reg(RegActiveLevel, 16'hFFFE);
    set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
    plan_presses(150, $urandom, 5, 40, 5);
    drain_and_wait();

    // long threshold above the very long one, timestamps wrap
    src_idle_on = 1'b1;
    sink_idle_on = 1'b0;
    set_thresholds(16'd3, 16'd30, 16'd120, 16'd60);
    plan_presses(300, 32'hFFFF_F000, 6, 250, 8);
    drain_and_wait();

    // all thresholds at their maximum
    sink_idle_on = 1'b1;
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    plan_presses(250, 32'hFFF0_0000, 8000, 150000, 3);
    drain_and_wait();

    for (round = 0; round < 3; round++) begin
      write_reg(RegActiveLevel, CfgDataWidth'($urandom));
      set_thresholds(thr_t'($urandom_range(0, 20)), thr_t'($urandom_range(0, 80)),
                     thr_t'($urandom_range(0, 200)), thr_t'($urandom_range(0, 300)));
      if (round == 1) squeeze_go = 1'b1;
      plan_presses(230, $urandom, 10, 400, 15);
      drain_and_wait();
    end

    quiet_tail = 1'b1;
    set_thresholds(16'd10, 16'd60, 16'd100, 16'd250);
    plan_presses(250, $urandom, 12, 350, 5);
    drain_and_wait();

    if (event_log.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_button_click_press_classifier: done, clean");
    end else begin
      $display("tb_button_click_press_classifier: done, errors");
    end
    $finish;
  end

endmodule

>>> button_click_press_classifier.f
rtl/core/bcpc_pkg.sv
rtl/core/bcpc_intf.sv
rtl/core/bcpc_cfg_regs.sv
rtl/core/bcpc_fsm.sv
rtl/core/bcpc_evt_fifo.sv
rtl/core/button_click_press_classifier.sv
rtl/core/bcpc_checker.sv
tb/tb_button_click_press_classifier.sv
